### rtl/core/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit partition allocator package
// Shared codes, field widths and the records passed between the allocator
// top level and its row of partition cells.
// ----------------------------------------------------------------------------
package bfpa_pkg;

  localparam int KIND_W    = 2;
  localparam int SIZE_W    = 16;
  localparam int OWNER_W   = 6;
  localparam int INDEX_W   = 3;
  localparam int STATUS_W  = 2;

  // Internal record widths cover the largest legal parameter values.
  localparam int REC_W       = 32;
  localparam int REC_IDX_W   = 6;
  localparam int REC_OWNER_W = 16;
  localparam int DEF_IDX_W   = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_DEFINE  = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  // Operation held steady by the top level while the search runs.
  typedef struct packed {
    kind_t                  kind;
    logic [SIZE_W-1:0]      req;
    logic [REC_OWNER_W-1:0] owner;
  } cmd_t;

  // Running search result handed from cell to cell.
  typedef struct packed {
    logic                 found;
    logic                 fits;
    logic [REC_IDX_W-1:0] idx;
    logic [REC_W-1:0]     left;
    logic [REC_W-1:0]     base;
    logic [REC_W-1:0]     size;
  } scan_rec_t;

  // Table update applied to one cell when the result is issued.
  typedef struct packed {
    logic                   en;
    kind_t                  kind;
    logic [REC_IDX_W-1:0]   idx;
    logic [REC_OWNER_W-1:0] owner;
    logic [REC_W-1:0]       base;
    logic [REC_W-1:0]       size;
  } commit_t;

endpackage

### rtl/core/bfpa_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocate, release, define or no-op beat.
// ----------------------------------------------------------------------------
interface bfpa_req_if;
  logic                          valid;
  logic                          ready;
  logic [bfpa_pkg::KIND_W-1:0]   kind;
  logic [bfpa_pkg::SIZE_W-1:0]   request_size;
  logic [bfpa_pkg::OWNER_W-1:0]  owner_id;
  logic [bfpa_pkg::INDEX_W-1:0]  entry_index;
  logic [bfpa_pkg::SIZE_W-1:0]   entry_base;
  logic [bfpa_pkg::SIZE_W-1:0]   entry_size;

  modport source (output valid, kind, request_size, owner_id, entry_index,
                  entry_base, entry_size, input ready);
  modport sink   (input valid, kind, request_size, owner_id, entry_index,
                  entry_base, entry_size, output ready);
endinterface

### rtl/core/bfpa_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result beat per request.
// ----------------------------------------------------------------------------
interface bfpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfpa_pkg::STATUS_W-1:0] status;
  logic [bfpa_pkg::INDEX_W-1:0]  slot;
  logic [bfpa_pkg::SIZE_W-1:0]   slot_base;
  logic [bfpa_pkg::SIZE_W-1:0]   slot_size;

  modport source (output valid, status, slot, slot_base, slot_size, input ready);
  modport sink   (input valid, status, slot, slot_base, slot_size, output ready);
endinterface

### rtl/core/bfpa_cell.sv
// ----------------------------------------------------------------------------
// Partition cell
// Holds one partition entry, folds it into the search record passing by and
// applies the table update addressed to it.
// ----------------------------------------------------------------------------
module bfpa_cell #(
  parameter int CELL_INDEX = 0,
  parameter int ADDR_BITS  = 16,
  parameter int OWNER_BITS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  bfpa_pkg::cmd_t      cmd,
  input  bfpa_pkg::commit_t   commit,
  input  bfpa_pkg::scan_rec_t rec_in,
  output bfpa_pkg::scan_rec_t rec_out
);

  logic [ADDR_BITS-1:0]  base;
  logic [ADDR_BITS-1:0]  size;
  logic [OWNER_BITS-1:0] owner;
  logic                  busy;

  bfpa_pkg::scan_rec_t       rec_next;
  logic [bfpa_pkg::REC_W-1:0] size_w;
  logic [bfpa_pkg::REC_W-1:0] req_w;
  logic [bfpa_pkg::REC_W-1:0] left;
  logic                       fit;
  logic                       take;
  logic                       hit;

  assign size_w = bfpa_pkg::REC_W'(size);
  assign req_w  = bfpa_pkg::REC_W'(cmd.req);
  assign fit    = (req_w <= size_w);
  assign left   = size_w - req_w;
  assign hit    = commit.en && (commit.idx == bfpa_pkg::REC_IDX_W'(CELL_INDEX));

  always_comb begin
    rec_next = rec_in;
    take     = 1'b0;
    case (cmd.kind)
      bfpa_pkg::KIND_ALLOC: begin
        if (fit) begin
          rec_next.fits = 1'b1;
          // Strictly smaller leftover only, so the lower index keeps a tie.
          take = !busy && (!rec_in.found || (left < rec_in.left));
        end
      end
      bfpa_pkg::KIND_RELEASE: begin
        take = !rec_in.found && busy &&
               (bfpa_pkg::REC_OWNER_W'(owner) == cmd.owner);
      end
      default: begin
        take = 1'b0;
      end
    endcase
    if (take) begin
      rec_next.found = 1'b1;
      rec_next.idx   = bfpa_pkg::REC_IDX_W'(CELL_INDEX);
      rec_next.left  = left;
      rec_next.base  = bfpa_pkg::REC_W'(base);
      rec_next.size  = size_w;
    end
  end

  always_ff @(posedge clk) begin
    rec_out <= rec_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      size  <= '0;
      owner <= '0;
      busy  <= 1'b0;
    end else if (hit) begin
      case (commit.kind)
        bfpa_pkg::KIND_ALLOC: begin
          busy  <= 1'b1;
          owner <= OWNER_BITS'(commit.owner);
        end
        bfpa_pkg::KIND_RELEASE: begin
          busy <= 1'b0;
        end
        bfpa_pkg::KIND_DEFINE: begin
          base  <= ADDR_BITS'(commit.base);
          size  <= ADDR_BITS'(commit.size);
          owner <= '0;
          busy  <= 1'b0;
        end
        default: begin
          busy <= busy;
        end
      endcase
    end
  end

endmodule

### rtl/core/best_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit partition allocator
// Fixed partition table searched by a row of cells for allocate and release.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel, one beat per operation: allocate
// (request_size, owner_id), release (owner_id), define (entry_index,
// entry_base, entry_size) or no-op. Every request yields exactly one beat on rsp.
// Each table entry lives in its own cell; a search record enters the first
// cell and moves one cell per clock, passing through the whole row during the
// search state; the result is then issued and the table updated together.
// The next request is taken only after the result has been issued, so a new
// request is never accepted while the previous one is still in the search.
// The result sits in an output register; while rsp.ready is low the next
// request is still accepted and searched, and its result waits in the final
// search state until the register is free. A define overwrites an entry even
// if busy; a define beyond the table changes nothing.
// Reset (synchronous, rst high) frees every partition and zeroes all bases,
// sizes and owners directly, with no clearing pass.
// ----------------------------------------------------------------------------
module best_fit_partition_allocator #(
  parameter int PARTITIONS = 8,
  parameter int ADDR_BITS  = 16,
  parameter int OWNER_BITS = 6
) (
  input logic        clk,
  input logic        rst,
  bfpa_req_if.sink   req,
  bfpa_rsp_if.source rsp
);

  localparam int CNT_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;

  bfpa_pkg::cmd_t              cmd;
  logic [bfpa_pkg::INDEX_W-1:0] def_idx;
  logic [ADDR_BITS-1:0]        def_base;
  logic [ADDR_BITS-1:0]        def_size;

  bfpa_pkg::scan_rec_t rec [0:PARTITIONS];
  bfpa_pkg::scan_rec_t fin;
  bfpa_pkg::commit_t   commit;

  logic                          accept;
  logic                          fire;
  logic                          def_ok;
  bfpa_pkg::status_t             res_status;
  logic [bfpa_pkg::INDEX_W-1:0]  res_slot;
  logic [bfpa_pkg::SIZE_W-1:0]   res_base;
  logic [bfpa_pkg::SIZE_W-1:0]   res_size;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fire      = (state == S_DONE) && (!rsp.valid || rsp.ready);
  assign rec[0]    = '0;
  assign fin       = rec[PARTITIONS];
  assign def_ok    = ({4'b0, def_idx} < bfpa_pkg::DEF_IDX_W'(PARTITIONS));

  for (genvar i = 0; i < PARTITIONS; i++) begin : g_cell
    bfpa_cell #(
      .CELL_INDEX (i),
      .ADDR_BITS  (ADDR_BITS),
      .OWNER_BITS (OWNER_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .commit  (commit),
      .rec_in  (rec[i]),
      .rec_out (rec[i+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_SCAN;
      S_SCAN: if (cnt == CNT_W'(PARTITIONS - 1)) state_next = S_DONE;
      S_DONE: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.kind  <= bfpa_pkg::kind_t'(req.kind);
      cmd.req   <= req.request_size;
      cmd.owner <= bfpa_pkg::REC_OWNER_W'(OWNER_BITS'(bfpa_pkg::REC_OWNER_W'(req.owner_id)));
      def_idx   <= req.entry_index;
      def_base  <= ADDR_BITS'(bfpa_pkg::REC_W'(req.entry_base));
      def_size  <= ADDR_BITS'(bfpa_pkg::REC_W'(req.entry_size));
    end
  end

  always_comb begin
    res_status   = bfpa_pkg::ST_OK;
    res_slot     = '0;
    res_base     = '0;
    res_size     = '0;
    commit.en    = 1'b0;
    commit.kind  = cmd.kind;
    commit.idx   = fin.idx;
    commit.owner = cmd.owner;
    commit.base  = bfpa_pkg::REC_W'(def_base);
    commit.size  = bfpa_pkg::REC_W'(def_size);
    case (cmd.kind)
      bfpa_pkg::KIND_ALLOC: begin
        if (fin.found) begin
          res_slot  = bfpa_pkg::INDEX_W'(fin.idx);
          res_base  = bfpa_pkg::SIZE_W'(fin.base);
          res_size  = bfpa_pkg::SIZE_W'(fin.size);
          commit.en = fire;
        end else if (fin.fits) begin
          res_status = bfpa_pkg::ST_FULL;
        end else begin
          res_status = bfpa_pkg::ST_TOO_BIG;
        end
      end
      bfpa_pkg::KIND_RELEASE: begin
        if (fin.found) begin
          res_slot  = bfpa_pkg::INDEX_W'(fin.idx);
          res_base  = bfpa_pkg::SIZE_W'(fin.base);
          res_size  = bfpa_pkg::SIZE_W'(fin.size);
          commit.en = fire;
        end else begin
          res_status = bfpa_pkg::ST_NONE;
        end
      end
      bfpa_pkg::KIND_DEFINE: begin
        res_slot   = def_idx;
        commit.idx = bfpa_pkg::REC_IDX_W'(def_idx);
        if (def_ok) begin
          res_base  = bfpa_pkg::SIZE_W'(def_base);
          res_size  = bfpa_pkg::SIZE_W'(def_size);
          commit.en = fire;
        end
      end
      default: begin
        res_status = bfpa_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status    <= res_status;
      rsp.slot      <= res_slot;
      rsp.slot_base <= res_base;
      rsp.slot_size <= res_size;
    end
  end

  // A table update is always paired with a result beat being loaded.
  a_commit_loads_result: assert property (@(posedge clk) disable iff (rst)
    commit.en |=> rsp.valid)
    else $error("table update without a result beat");

  // A failed allocate or release must never touch the table.
  a_no_commit_on_miss: assert property (@(posedge clk) disable iff (rst)
    (fire && (cmd.kind == bfpa_pkg::KIND_ALLOC || cmd.kind == bfpa_pkg::KIND_RELEASE)
     && !fin.found) |-> !commit.en)
    else $error("table update on a failed search");

  // Every accepted request starts a fresh search from the first cell.
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN) && (cnt == '0))
    else $error("search did not start after request beat");

  // The search counter never runs past the end of the row.
  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt <= CNT_W'(PARTITIONS - 1)))
    else $error("search counter overran the row");

endmodule

### tb/tb_best_fit_partition_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit partition allocator testbench
// Drives allocate, release, define and no-op beats into the allocator and
// checks every response against a predictor that keeps its own partition
// table. A directed opening is followed by random traffic over three idling
// phases, with one long response stall that backs up the request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_best_fit_partition_allocator;

  localparam int NUM_PARTS     = 8;
  localparam int PHASE_ITEMS   = 475;
  localparam int HOLD_AT       = 1150;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    bfpa_pkg::kind_t kind;
    logic [15:0]     request_size;
    logic [5:0]      owner;
    logic [2:0]      index;
    logic [15:0]     base;
    logic [15:0]     size;
  } request_t;

  typedef struct {
    bfpa_pkg::status_t status;
    logic [2:0]        slot;
    logic [15:0]       base;
    logic [15:0]       size;
  } grant_t;

  logic clk = 1'b0;
  logic rst;

  bfpa_req_if req_ch ();
  bfpa_rsp_if rsp_ch ();

  best_fit_partition_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the partition table.
  logic [15:0] tbl_base  [NUM_PARTS];
  logic [15:0] tbl_size  [NUM_PARTS];
  logic [5:0]  tbl_owner [NUM_PARTS];
  logic        tbl_busy  [NUM_PARTS];

  request_t request_queue[$];
  grant_t   grant_queue[$];
  request_t offered;
  grant_t   want;

  int send_idle_pct;
  int recv_idle_pct;
  int requests_taken;
  int failures;
  int idle_cycles;
  int hold_left;
  bit hold_done;

  // Generator's rough view of partition sizes, used to aim requests at fits.
  logic [15:0] sizes_seen [NUM_PARTS];

  function automatic grant_t serve_request(request_t r);
    grant_t      g;
    bit          found;
    bit          fits;
    int          best;
    logic [15:0] left;
    logic [15:0] best_left;
    g.status = bfpa_pkg::ST_OK;
    g.slot   = '0;
    g.base   = '0;
    g.size   = '0;
    found     = 1'b0;
    fits      = 1'b0;
    best      = 0;
    best_left = '0;
    case (r.kind)
      bfpa_pkg::KIND_ALLOC: begin
        for (int i = 0; i < NUM_PARTS; i++) begin
          if (r.request_size <= tbl_size[i]) begin
            left = tbl_size[i] - r.request_size;
            fits = 1'b1;
            if (!tbl_busy[i] && (!found || left < best_left)) begin
              found     = 1'b1;
              best      = i;
              best_left = left;
            end
          end
        end
        if (found) begin
          tbl_busy[best]  = 1'b1;
          tbl_owner[best] = r.owner;
          g.slot = best[2:0];
          g.base = tbl_base[best];
          g.size = tbl_size[best];
        end else if (fits) begin
          g.status = bfpa_pkg::ST_FULL;
        end else begin
          g.status = bfpa_pkg::ST_TOO_BIG;
        end
      end
      bfpa_pkg::KIND_RELEASE: begin
        g.status = bfpa_pkg::ST_NONE;
        for (int i = 0; i < NUM_PARTS; i++) begin
          if (!found && tbl_busy[i] && tbl_owner[i] == r.owner) begin
            found       = 1'b1;
            tbl_busy[i] = 1'b0;
            g.status    = bfpa_pkg::ST_OK;
            g.slot      = i[2:0];
            g.base      = tbl_base[i];
            g.size      = tbl_size[i];
          end
        end
      end
      bfpa_pkg::KIND_DEFINE: begin
        // Redefining an entry drops any current holder.
        tbl_base[r.index]  = r.base;
        tbl_size[r.index]  = r.size;
        tbl_owner[r.index] = '0;
        tbl_busy[r.index]  = 1'b0;
        g.slot = r.index;
        g.base = r.base;
        g.size = r.size;
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  // Fields that the kind does not use carry random noise.
  task automatic push_request(bfpa_pkg::kind_t k, int req_sz, int own, int idx, int eb,
                              int es);
    request_t r;
    r.kind         = k;
    r.request_size = (k == bfpa_pkg::KIND_ALLOC) ? req_sz[15:0] : 16'($urandom);
    r.owner        = (k == bfpa_pkg::KIND_ALLOC || k == bfpa_pkg::KIND_RELEASE) ?
                     own[5:0] : 6'($urandom);
    r.index        = (k == bfpa_pkg::KIND_DEFINE) ? idx[2:0] : 3'($urandom);
    r.base         = (k == bfpa_pkg::KIND_DEFINE) ? eb[15:0] : 16'($urandom);
    r.size         = (k == bfpa_pkg::KIND_DEFINE) ? es[15:0] : 16'($urandom);
    request_queue.push_back(r);
  endtask

  task automatic push_random_traffic(int count);
    int roll;
    int sz;
    int own;
    int idx;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      own  = ($urandom_range(99) < 85) ? $urandom_range(7) : $urandom_range(63);
      if (roll < 45) begin
        roll = $urandom_range(99);
        sz   = sizes_seen[$urandom_range(NUM_PARTS - 1)];
        if (roll < 55) begin
          sz = sz - $urandom_range(3);
          if (sz < 0) sz = 0;
        end else if (roll < 70) begin
          sz = sz + $urandom_range(1, 3);
          if (sz > 65535) sz = 65535;
        end else if (roll < 85) begin
          sz = $urandom_range(255);
        end else begin
          sz = $urandom_range(65535);
        end
        push_request(bfpa_pkg::KIND_ALLOC, sz, own, 0, 0, 0);
      end else if (roll < 80) begin
        push_request(bfpa_pkg::KIND_RELEASE, 0, own, 0, 0, 0);
      end else if (roll < 95) begin
        idx  = $urandom_range(NUM_PARTS - 1);
        roll = $urandom_range(99);
        if (roll < 35) begin
          case ($urandom_range(6))
            0: sz = 0;
            1: sz = 1;
            2: sz = 16;
            3: sz = 100;
            4: sz = 255;
            5: sz = 4096;
            default: sz = 65535;
          endcase
        end else if (roll < 65) begin
          // Copying another entry's size sets up leftover ties.
          sz = sizes_seen[$urandom_range(NUM_PARTS - 1)];
        end else begin
          sz = $urandom_range(65535);
        end
        sizes_seen[idx] = sz[15:0];
        push_request(bfpa_pkg::KIND_DEFINE, 0, 0, idx, $urandom_range(65535), sz);
      end else begin
        push_request(bfpa_pkg::KIND_NOP, 0, 0, 0, 0, 0);
      end
    end
  endtask

  task automatic wait_drained();
    while (request_queue.size() > 0 || req_ch.valid || grant_queue.size() > 0)
      @(negedge clk);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      failures++;
    end
  endtask

  // Request driver: a new beat is offered once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        grant_queue.push_back(serve_request(offered));
        requests_taken <= requests_taken + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = request_queue.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.kind         <= offered.kind;
          req_ch.request_size <= offered.request_size;
          req_ch.owner_id     <= offered.owner;
          req_ch.entry_index  <= offered.index;
          req_ch.entry_base   <= offered.base;
          req_ch.entry_size   <= offered.size;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response ready, with one long hold-off while requests keep coming.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && requests_taken >= HOLD_AT) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (grant_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                 $time, rsp_ch.status, rsp_ch.slot);
        failures++;
      end else begin
        want = grant_queue.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("slot", want.slot, rsp_ch.slot);
        check_field("slot_base", want.base, rsp_ch.slot_base);
        check_field("slot_size", want.size, rsp_ch.slot_size);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("** best_fit_partition_allocator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.kind         = bfpa_pkg::KIND_NOP;
    req_ch.request_size = '0;
    req_ch.owner_id     = '0;
    req_ch.entry_index  = '0;
    req_ch.entry_base   = '0;
    req_ch.entry_size   = '0;
    rsp_ch.ready        = 1'b0;
    requests_taken      = 0;
    failures            = 0;
    hold_left           = 0;
    hold_done           = 1'b0;
    send_idle_pct       = 24;
    recv_idle_pct       = 85;
    for (int i = 0; i < NUM_PARTS; i++) begin
      tbl_base[i]   = '0;
      tbl_size[i]   = '0;
      tbl_owner[i]  = '0;
      tbl_busy[i]   = 1'b0;
      sizes_seen[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty table: zero-size requests fit the never-defined entries.
    push_request(bfpa_pkg::KIND_ALLOC, 0, 63, 0, 0, 0);
    push_request(bfpa_pkg::KIND_ALLOC, 0, 1, 0, 0, 0);
    push_request(bfpa_pkg::KIND_ALLOC, 1, 2, 0, 0, 0);
    push_request(bfpa_pkg::KIND_RELEASE, 0, 40, 0, 0, 0);
    push_request(bfpa_pkg::KIND_RELEASE, 0, 63, 0, 0, 0);
    push_request(bfpa_pkg::KIND_NOP, 0, 0, 0, 0, 0);
    push_request(bfpa_pkg::KIND_DEFINE, 0, 0, 0, 16'hFFFF, 16'hFFFF);
    push_request(bfpa_pkg::KIND_DEFINE, 0, 0, 1, 16'h0000, 16'h0000);
    push_request(bfpa_pkg::KIND_DEFINE, 0, 0, 3, 16'h1234, 100);
    push_request(bfpa_pkg::KIND_DEFINE, 0, 0, 5, 16'h4000, 100);
    push_request(bfpa_pkg::KIND_DEFINE, 0, 0, 7, 16'h8000, 200);
    // Equal leftovers go to the lower index, then the tighter fit wins.
    push_request(bfpa_pkg::KIND_ALLOC, 100, 7, 0, 0, 0);
    push_request(bfpa_pkg::KIND_ALLOC, 100, 7, 0, 0, 0);
    push_request(bfpa_pkg::KIND_ALLOC, 100, 8, 0, 0, 0);
    push_request(bfpa_pkg::KIND_ALLOC, 50, 9, 0, 0, 0);
    push_request(bfpa_pkg::KIND_ALLOC, 1, 10, 0, 0, 0);
    push_request(bfpa_pkg::KIND_ALLOC, 16'hFFFF, 10, 0, 0, 0);
    push_request(bfpa_pkg::KIND_RELEASE, 0, 7, 0, 0, 0);
    // Redefining a busy entry takes it away from its holder.
    push_request(bfpa_pkg::KIND_DEFINE, 0, 0, 5, 16'h5555, 300);
    push_request(bfpa_pkg::KIND_RELEASE, 0, 7, 0, 0, 0);
    push_request(bfpa_pkg::KIND_ALLOC, 0, 0, 0, 0, 0);
    push_request(bfpa_pkg::KIND_RELEASE, 0, 0, 0, 0, 0);
    push_request(bfpa_pkg::KIND_DEFINE, 0, 0, 2, 16'hAAAA, 16'h5555);
    push_request(bfpa_pkg::KIND_RELEASE, 0, 9, 0, 0, 0);
    push_request(bfpa_pkg::KIND_ALLOC, 16'hFFFF, 63, 0, 0, 0);
    sizes_seen[0] = 16'hFFFF;
    sizes_seen[2] = 16'h5555;
    sizes_seen[3] = 100;
    sizes_seen[5] = 300;
    sizes_seen[7] = 200;

    push_random_traffic(PHASE_ITEMS);
    wait_drained();
    send_idle_pct = 85;
    recv_idle_pct = 24;
    push_random_traffic(PHASE_ITEMS);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_traffic(PHASE_ITEMS);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failures == 0 && grant_queue.size() == 0) begin
      $display("** best_fit_partition_allocator: PASSED **");
    end else begin
      $display("** best_fit_partition_allocator: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bfpa_pkg.sv
rtl/core/bfpa_req_if.sv
rtl/core/bfpa_rsp_if.sv
rtl/core/bfpa_cell.sv
rtl/core/best_fit_partition_allocator.sv
tb/tb_best_fit_partition_allocator.sv
